// ===== sv/kth_largest_min_heap_macros.svh =====
// assertion macros used by the heap sequencer
`ifndef KTH_LARGEST_MIN_HEAP_MACROS_SVH
`define KTH_LARGEST_MIN_HEAP_MACROS_SVH

// condition holds at every edge out of reset
`define KTHM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define KTHM_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define KTHM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/kthm_pkg.sv =====
// shared constants, types and helpers for the k-th largest heap
`timescale 1ns / 1ps

package kthm_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned RankW      = 9;
  localparam int unsigned DefMaxRank = 256;
  localparam int unsigned ApbAddrW   = 3;

  // register select bit of paddr (byte address 4*i)
  localparam logic RegTargetRank = 1'b0;

  // heap memory control request
  typedef struct packed {
    logic             we;
    logic             re;
    logic [DataW-1:0] wdata;
  } mem_ctl_t;

  // signed compare of two's complement words: a < b
  function automatic logic less_signed(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ===== sv/kthm_mem.sv =====
// heap storage: one write port, two registered read ports
`timescale 1ns / 1ps

module kthm_mem #(
  parameter int unsigned Depth = kthm_pkg::DefMaxRank,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                         clk_i,
  input  kthm_pkg::mem_ctl_t           ctl_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  logic [AddrW-1:0]             raddr_a_i,
  input  logic [AddrW-1:0]             raddr_b_i,
  output logic [kthm_pkg::DataW-1:0]   rdata_a_o,
  output logic [kthm_pkg::DataW-1:0]   rdata_b_o
);
  import kthm_pkg::*;

  logic [DataW-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= ctl_i.wdata;
    end
  end

  // read ports, registered on a read enable
  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== sv/kthm_regs.sv =====
// apb register file holding the target rank
`timescale 1ns / 1ps

module kthm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kthm_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [kthm_pkg::RankW-1:0]    target_rank_o
);
  import kthm_pkg::*;

  logic [RankW-1:0] rank_q, rank_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register write decode
  always_comb begin
    rank_d = rank_q;
    if (wr_en && (paddr[2] == RegTargetRank)) begin
      rank_d = pwdata[RankW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RankW'(1);
    end else begin
      rank_q <= rank_d;
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      RegTargetRank: prdata = 32'(rank_q);
      default:       prdata = '0;
    endcase
  end

  assign target_rank_o = rank_q;

endmodule

// ===== sv/kthm_ctrl.sv =====
// heap sequencer: insert with sift-up, replace root with sift-down, or discard
`timescale 1ns / 1ps
`include "kth_largest_min_heap_macros.svh"

module kthm_ctrl #(
  parameter int unsigned MAX_RANK = kthm_pkg::DefMaxRank,
  parameter int unsigned AddrW    = $clog2(MAX_RANK)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [kthm_pkg::DataW-1:0] s_data_i,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [kthm_pkg::DataW-1:0] m_data_o,
  output logic                       m_full_o,
  input  logic [kthm_pkg::RankW-1:0] target_rank_i,
  output kthm_pkg::mem_ctl_t         mem_ctl_o,
  output logic [AddrW-1:0]           waddr_o,
  output logic [AddrW-1:0]           raddr_a_o,
  output logic [AddrW-1:0]           raddr_b_o,
  input  logic [kthm_pkg::DataW-1:0] rdata_a_i,
  input  logic [kthm_pkg::DataW-1:0] rdata_b_i
);
  import kthm_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RANK + 1);
  localparam int unsigned KW   = (CntW > RankW) ? CntW : RankW;
  localparam int unsigned ChW  = AddrW + 2;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StUpRd  = 6'b000010,
    StUpCmp = 6'b000100,
    StDnRd  = 6'b001000,
    StDnCmp = 6'b010000,
    StDone  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [DataW-1:0] val_q, val_d;
  logic [DataW-1:0] root_q;
  logic             m_valid_q;
  logic [DataW-1:0] m_data_q;
  logic             m_full_q;

  logic [KW-1:0]    rank_ext, max_k, eff_k, count_ext;
  logic             fill, full_now, out_load;
  logic [AddrW-1:0] parent;
  logic [ChW-1:0]   left_idx, right_idx, cnt_ch;
  logic             take_left, take_right;
  logic [DataW-1:0] cand_val;
  mem_ctl_t         mem_ctl;

  // effective rank clamped to 1..MAX_RANK
  assign rank_ext  = KW'(target_rank_i);
  assign max_k     = KW'(MAX_RANK);
  assign eff_k     = (rank_ext == '0) ? KW'(1) : ((rank_ext > max_k) ? max_k : rank_ext);
  assign count_ext = KW'(count_q);
  assign fill      = count_ext < eff_k;
  assign full_now  = count_ext >= eff_k;

  // heap index arithmetic
  assign parent    = AddrW'((pos_q - AddrW'(1)) >> 1);
  assign left_idx  = (ChW'(pos_q) << 1) + ChW'(1);
  assign right_idx = left_idx + ChW'(1);
  assign cnt_ch    = ChW'(count_q);

  // child selection, left wins ties
  assign take_left  = less_signed(rdata_a_i, val_q);
  assign cand_val   = take_left ? rdata_a_i : val_q;
  assign take_right = (right_idx < cnt_ch) && less_signed(rdata_b_i, cand_val);

  assign out_load  = (state_q == StDone) && (!m_valid_q || m_ready_i);
  assign s_ready_o = (state_q == StIdle);

  // sequencer
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    pos_d         = pos_q;
    val_d         = val_q;
    mem_ctl.we    = 1'b0;
    mem_ctl.re    = 1'b0;
    mem_ctl.wdata = val_q;
    raddr_a_o     = parent;
    raddr_b_o     = right_idx[AddrW-1:0];
    case (state_q)
      StIdle: begin
        if (s_valid_i) begin
          val_d = s_data_i;
          if (fill) begin
            pos_d   = count_q[AddrW-1:0];
            count_d = count_q + CntW'(1);
            state_d = StUpRd;
          end else if (less_signed(root_q, s_data_i)) begin
            pos_d   = '0;
            state_d = StDnRd;
          end else begin
            state_d = StDone;
          end
        end
      end
      StUpRd: begin
        if (pos_q == '0) begin
          mem_ctl.we = 1'b1;
          state_d    = StDone;
        end else begin
          mem_ctl.re = 1'b1;
          state_d    = StUpCmp;
        end
      end
      StUpCmp: begin
        mem_ctl.we = 1'b1;
        if (less_signed(val_q, rdata_a_i)) begin
          mem_ctl.wdata = rdata_a_i;
          pos_d         = parent;
          state_d       = StUpRd;
        end else begin
          state_d = StDone;
        end
      end
      StDnRd: begin
        raddr_a_o = left_idx[AddrW-1:0];
        if (left_idx >= cnt_ch) begin
          mem_ctl.we = 1'b1;
          state_d    = StDone;
        end else begin
          mem_ctl.re = 1'b1;
          state_d    = StDnCmp;
        end
      end
      StDnCmp: begin
        mem_ctl.we = 1'b1;
        if (take_right) begin
          mem_ctl.wdata = rdata_b_i;
          pos_d         = right_idx[AddrW-1:0];
          state_d       = StDnRd;
        end else if (take_left) begin
          mem_ctl.wdata = rdata_a_i;
          pos_d         = left_idx[AddrW-1:0];
          state_d       = StDnRd;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign mem_ctl_o = mem_ctl;
  assign waddr_o   = pos_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, root mirrors entry zero
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    if (mem_ctl.we && (pos_q == '0)) begin
      root_q <= mem_ctl.wdata;
    end
    if (out_load) begin
      m_data_q <= root_q;
      m_full_q <= full_now;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_full_o  = m_full_q;

  // checks
  `KTHM_ASSERT_ALWAYS(a_count_range, count_q <= CntW'(MAX_RANK), "count above capacity")
  `KTHM_ASSERT_NEXT(a_fill_count, s_valid_i && s_ready_o && fill, count_q == $past(count_q) + CntW'(1), "fill did not grow count")
  `KTHM_ASSERT_IMPL(a_write_state, mem_ctl.we, !(state_q == StIdle || state_q == StDone), "heap write outside sift")
  `KTHM_ASSERT_IMPL(a_pos_bound, state_q == StUpRd || state_q == StUpCmp || state_q == StDnCmp, CntW'(pos_q) < count_q, "sift position beyond heap")
  `KTHM_ASSERT_IMPL(a_result_src, $rose(m_valid_q), $past(state_q == StDone), "result loaded outside done")

endmodule

// ===== sv/kth_largest_min_heap.sv =====
// k-th largest of a stream kept in a min-heap in one memory
// sequence: a discard goes straight to the result; an insert reads, compares and writes
//   per level moved up, a replace does so per level moved down, and each then writes the
//   new value where its walk stops
// throughput: one request at a time, the next taken in the cycle after the result loads,
//   which waits for the output to be free; the read-compare-write heap walk sets the pace
// reset: asynchronous active low, empties the heap and sets target_rank to 1
`timescale 1ns / 1ps

module kth_largest_min_heap #(
  parameter int unsigned MAX_RANK = kthm_pkg::DefMaxRank
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample request
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [kthm_pkg::DataW-1:0]    s_axis_tdata,  // [31:0] sample_value
  // result
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [kthm_pkg::DataW-1:0]    m_axis_tdata,  // [31:0] kth_value
  output logic [0:0]                    m_axis_tuser,  // [0] heap_full
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kthm_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import kthm_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_RANK);

  logic [RankW-1:0] target_rank;
  mem_ctl_t         mem_ctl;
  logic [AddrW-1:0] waddr, raddr_a, raddr_b;
  logic [DataW-1:0] rdata_a, rdata_b;
  logic             full_flag;

  kthm_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .target_rank_o(target_rank)
  );

  kthm_mem #(
    .Depth(MAX_RANK),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i    (clk_i),
    .ctl_i    (mem_ctl),
    .waddr_i  (waddr),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  kthm_ctrl #(
    .MAX_RANK(MAX_RANK),
    .AddrW   (AddrW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata),
    .m_full_o     (full_flag),
    .target_rank_i(target_rank),
    .mem_ctl_o    (mem_ctl),
    .waddr_o      (waddr),
    .raddr_a_o    (raddr_a),
    .raddr_b_o    (raddr_b),
    .rdata_a_i    (rdata_a),
    .rdata_b_i    (rdata_b)
  );

  assign m_axis_tuser[0] = full_flag;

endmodule

// ===== dv/kth_largest_min_heap_checker.sv =====
// result checker for the k-th largest heap: watches both streams and the config port
`timescale 1ns / 1ps

module kth_largest_min_heap_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [kthm_pkg::DataW-1:0]    s_axis_tdata,  // [31:0] sample_value
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [kthm_pkg::DataW-1:0]    m_axis_tdata,  // [31:0] kth_value
  input  logic [0:0]                    m_axis_tuser,  // [0] heap_full
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kthm_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int unsigned                   failures_o,
  output int unsigned                   pending_o
);

  import kthm_pkg::*;

  localparam int unsigned HeapDepth = DefMaxRank;
  localparam logic [ApbAddrW-1:0] RankAddr = {RegTargetRank, 2'b00};

  typedef struct packed {
    logic [DataW-1:0] kth_value;
    logic             heap_full;
  } rank_result_t;

  // own copy of the heap, its fill level and the rank register
  logic [DataW-1:0] held_values [HeapDepth];
  int unsigned      held_count;
  logic [RankW-1:0] rank_reg;
  rank_result_t     pending_roots [$];
  rank_result_t     oldest;

  // rank clamped into 1..HeapDepth
  function automatic int unsigned active_rank();
    if (rank_reg == '0) return 1;
    if (rank_reg > HeapDepth) return HeapDepth;
    return rank_reg;
  endfunction

  function automatic void swap_held(int unsigned a, int unsigned b);
    logic [DataW-1:0] t;
    t = held_values[a];
    held_values[a] = held_values[b];
    held_values[b] = t;
  endfunction

  // new tail entry moves up while smaller than its parent
  function automatic void raise_entry(int unsigned pos);
    int unsigned parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if ($signed(held_values[pos]) >= $signed(held_values[parent])) break;
      swap_held(pos, parent);
      pos = parent;
    end
  endfunction

  // replaced root moves down toward the smaller child, left wins a tie
  function automatic void lower_root(int unsigned cnt);
    int unsigned pos, left, right, best;
    pos = 0;
    while (2 * pos + 1 < cnt) begin
      left  = 2 * pos + 1;
      right = left + 1;
      best  = pos;
      if ($signed(held_values[left]) < $signed(held_values[best])) best = left;
      if (right < cnt && $signed(held_values[right]) < $signed(held_values[best])) best = right;
      if (best == pos) break;
      swap_held(pos, best);
      pos = best;
    end
  endfunction

  // fold one sample into the heap and return the root and fill flag
  function automatic rank_result_t absorb_sample(logic [DataW-1:0] v);
    rank_result_t r;
    int unsigned k;
    k = active_rank();
    if (held_count < k) begin
      held_values[held_count] = v;
      raise_entry(held_count);
      held_count++;
    end else if ($signed(held_values[0]) < $signed(v)) begin
      held_values[0] = v;
      lower_root(held_count > HeapDepth ? HeapDepth : held_count);
    end
    r.kth_value = held_values[0];
    r.heap_full = (held_count >= k);
    return r;
  endfunction

  // predict on accepted samples, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      rank_reg   = 9'd1;
      pending_roots.delete();
      pending_o  = 0;
      failures_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_roots.push_back(absorb_sample(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_roots.size() == 0) begin
          $error("result with no request outstanding: kth_value %0d heap_full %0d",
                 $signed(m_axis_tdata), m_axis_tuser[0]);
          failures_o++;
        end else begin
          oldest = pending_roots.pop_front();
          if (m_axis_tdata !== oldest.kth_value) begin
            $error("kth_value: expected %0d, got %0d", $signed(oldest.kth_value),
                   $signed(m_axis_tdata));
            failures_o++;
          end
          if (m_axis_tuser[0] !== oldest.heap_full) begin
            $error("heap_full: expected %0d, got %0d", oldest.heap_full, m_axis_tuser[0]);
            failures_o++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == RankAddr) begin
        rank_reg = pwdata[RankW-1:0];
      end
      pending_o = pending_roots.size();
    end
  end

endmodule

// ===== dv/kth_largest_min_heap_tb.sv =====
// testbench top for the k-th largest heap: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module kth_largest_min_heap_tb;

  import kthm_pkg::*;

  localparam logic [ApbAddrW-1:0] RankAddr  = {RegTargetRank, 2'b00};
  localparam logic [DataW-1:0]    MinSample = 32'h8000_0000;
  localparam logic [DataW-1:0]    MaxSample = 32'h7fff_ffff;
  localparam logic [DataW-1:0]    AllOnes   = 32'hffff_ffff;
  localparam int unsigned         StallLen  = 400;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata;   // [31:0] sample_value
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [DataW-1:0]    m_axis_tdata;   // [31:0] kth_value
  logic [0:0]          m_axis_tuser;   // [0] heap_full
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int unsigned         failures;
  int unsigned         pending;

  // calm: no gaps on either side; stall_req: one long receiver hold-off
  bit calm;
  bit stall_req;

  kth_largest_min_heap u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  kth_largest_min_heap_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .failures_o(failures), .pending_o(pending)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sample mix: full range, tight cluster for ties, extremes, mid range
  function automatic logic [DataW-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 65) return 32'($urandom_range(0, 12)) - 32'd6;
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return MinSample;
        1: return MaxSample;
        2: return '0;
        default: return AllOnes;
      endcase
    end
    return 32'($urandom_range(0, 2000)) - 32'd1000;
  endfunction

  // offer one sample and wait for its handshake
  task automatic send_sample(input logic [DataW-1:0] v);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // setup then access cycle on the config port
  task automatic write_rank(input logic [RankW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RankAddr;
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // random phase at one rank setting
  task automatic run_phase(input logic [RankW-1:0] rank, input int unsigned n,
                           input bit quiet, input bit hold);
    drain();
    write_rank(rank);
    calm = quiet;
    if (hold) stall_req = 1'b1;
    repeat (n) send_sample(pick_sample());
    calm = 1'b0;
  endtask

  // receiver: random runs of ready and not ready, one forced long hold-off
  initial begin
    int unsigned hold_cycles;
    bit          rdy;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (stall_req) begin
        stall_req   = 1'b0;
        rdy         = 1'b0;
        hold_cycles = StallLen;
      end else if (calm) begin
        rdy         = 1'b1;
        hold_cycles = 1;
      end else begin
        rdy         = ($urandom_range(0, 99) < 65);
        hold_cycles = rdy ? $urandom_range(1, 8) : pick_gap() + 1;
      end
      m_axis_tready <= rdy;
      repeat (hold_cycles) @(posedge clk_i);
    end
  end

  // stimulus and verdict
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    stall_req     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rank 1 out of reset: extremes, ties at the root, discards
    send_sample(MinSample);
    send_sample(MinSample);
    send_sample(MaxSample);
    send_sample(32'd5);
    send_sample(MaxSample);
    send_sample('0);

    // rank 0 acts as 1
    drain();
    write_rank(9'd0);
    send_sample(AllOnes);
    send_sample(MaxSample);
    send_sample(32'd1);

    // rank 4: filling resumes, then equal children on sift-down
    drain();
    write_rank(9'd4);
    send_sample(AllOnes);
    send_sample(32'd3);
    send_sample(32'd3);
    send_sample(AllOnes);
    send_sample(32'd3);
    send_sample(32'd3);
    send_sample(MinSample);
    send_sample(32'd7);

    // rank lowered below the count: whole held heap competes
    drain();
    write_rank(9'd2);
    send_sample(32'd7);
    send_sample(32'd8);
    send_sample(32'd8);
    send_sample(MaxSample);

    // random phases over several ranks, extremes included
    run_phase(9'd16, 200, 1'b0, 1'b0);
    run_phase(9'd3, 100, 1'b1, 1'b0);
    run_phase(9'd64, 250, 1'b0, 1'b0);
    run_phase(9'd300, 300, 1'b1, 1'b1);
    run_phase(9'd511, 250, 1'b0, 1'b0);
    run_phase(9'd256, 250, 1'b0, 1'b0);
    run_phase(9'd1, 150, 1'b0, 1'b0);
    run_phase(9'd128, 200, 1'b0, 1'b0);

    drain();
    repeat (40) @(posedge clk_i);
    if (pending != 0) $error("%0d results never arrived", pending);
    if (failures == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #12_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
